[design/escp_printer_command_interpreter_macros.svh]
// assertion macros shared by the printer command interpreter modules
`ifndef ESCP_PRINTER_COMMAND_INTERPRETER_MACROS_SVH
`define ESCP_PRINTER_COMMAND_INTERPRETER_MACROS_SVH
`ifndef SYNTHESIS
`define ESCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ESCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ESCP_ASSERT(lbl, prop, msg)
`define ESCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[design/escp_pkg.sv]
// shared types and constants of the printer command interpreter
`timescale 1ns / 1ps
package escp_pkg;

  localparam int unsigned JobQDepth = 2;

  localparam logic [19:0] XMax          = 20'hFFFFF;
  localparam logic [11:0] MarginLeftRst = 12'd96;
  localparam logic [11:0] MarginTopRst  = 12'd160;
  localparam logic [13:0] PageLenRst    = 14'd7920;
  localparam logic [7:0]  DefColsRst    = 8'd80;
  localparam logic [13:0] RightLimitRst = 14'd5760;

  typedef enum logic [1:0] {
    KindDot   = 2'd0,
    KindGlyph = 2'd1,
    KindPage  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [11:0] margin_left;
    logic [11:0] margin_top;
    logic [13:0] page_length;
    logic [7:0]  default_columns;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pitch;
    logic       underline;
    logic       superscript;
    logic       subscript;
    logic       expanded;
    logic       bold;
    logic       double_strike;
  } attr_t;

  // work for the back end: optional glyph, up to eight strikes, optional page end
  typedef struct packed {
    attr_t       attr;
    logic        glyph_v;
    logic [7:0]  glyph_index;
    logic [20:0] gx;
    logic [14:0] gy;
    logic [7:0]  dots;
    logic [20:0] dx;
    logic [14:0] dy0;
    logic        pin9;
    logic        page_v;
  } job_t;

endpackage

[design/escp_in_if.sv]
// byte stream channel
`timescale 1ns / 1ps
interface escp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

[design/escp_out_if.sv]
// result channel
`timescale 1ns / 1ps
interface escp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [20:0] x_pos;
  logic [14:0] y_pos;
  logic [7:0]  glyph_index;
  logic [7:0]  pitch;
  logic        underline;
  logic        superscript;
  logic        subscript;
  logic        expanded;
  logic        bold;
  logic        double_strike;
  logic        last;
  modport source (output valid, output kind, output x_pos, output y_pos, output glyph_index,
                  output pitch, output underline, output superscript, output subscript,
                  output expanded, output bold, output double_strike, output last,
                  input ready);
  modport sink (input valid, input kind, input x_pos, input y_pos, input glyph_index,
                input pitch, input underline, input superscript, input subscript,
                input expanded, input bold, input double_strike, input last,
                output ready);
endinterface

[design/escp_front.sv]
// command decoder: parses the byte stream, keeps printer state, queues output work
`timescale 1ns / 1ps
module escp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  escp_pkg::cfg_t cfg_i,
  escp_in_if.sink       in_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output escp_pkg::job_t q_job_o
);
  import escp_pkg::*;

  typedef enum logic {SIdle, STab} state_e;

  typedef enum logic [4:0] {
    PhIdle, PhEsc, PhSkip1, PhSkip2, PhSkip3, PhSkipZ, PhQual, PhLsA, PhLs3, PhLsJ,
    PhPlen, PhRmar, PhGmode, PhCset, PhUndl, PhScript, PhWide, PhMaster, PhAbsLo,
    PhAbsHi, PhRelLo, PhRelHi, PhC9Lo, PhC9Hi, PhC24Lo, PhC24Hi, PhDot9, PhDot24
  } phase_e;

  typedef struct packed {
    logic       ok;
    logic       pin24;
    logic [3:0] step;
    logic       fast;
  } gmode_t;

  localparam logic [7:0] CcNul = 8'd0,  CcBel = 8'd7,  CcBs  = 8'd8,  CcHt  = 8'd9;
  localparam logic [7:0] CcLf  = 8'd10, CcVt  = 8'd11, CcFf  = 8'd12, CcCr  = 8'd13;
  localparam logic [7:0] CcSo  = 8'd14, CcSi  = 8'd15, CcDc1 = 8'd17, CcDc2 = 8'd18;
  localparam logic [7:0] CcDc3 = 8'd19, CcDc4 = 8'd20, CcCan = 8'd24, CcEm  = 8'd25;
  localparam logic [7:0] CcEsc = 8'd27, CcDel = 8'd127;

  localparam int StEl = 0, StKs = 1, StFe = 2, StDo = 3, StSp = 4, StUn = 5;
  localparam int ScSup = 0, ScSub = 1;

  function automatic logic [7:0] pitch_of(logic [5:0] st);
    logic [7:0] a;
    a = 8'd72;
    if (st[StEl]) a = 8'd60;
    else if (st[StKs]) a = 8'd42;
    if (st[StSp]) a = {a[6:0], 1'b0};
    return a;
  endfunction

  function automatic logic [19:0] sat_add(logic [19:0] x, logic [7:0] d);
    logic [20:0] s;
    s = {1'b0, x} + {13'b0, d};
    return s[20] ? XMax : s[19:0];
  endfunction

  // 72 times the column count, wide enough to see saturation
  function automatic logic [14:0] cols_x72(logic [7:0] cols);
    return {1'b0, cols, 6'b0} + {4'b0, cols, 3'b0};
  endfunction

  function automatic gmode_t gmode_of(logic [7:0] m);
    gmode_t g;
    g = '0;
    case (m)
      8'd0:    g = '{1'b1, 1'b0, 4'd12, 1'b0};
      8'd1:    g = '{1'b1, 1'b0, 4'd6,  1'b0};
      8'd2:    g = '{1'b1, 1'b0, 4'd6,  1'b1};
      8'd3:    g = '{1'b1, 1'b0, 4'd3,  1'b1};
      8'd4:    g = '{1'b1, 1'b0, 4'd9,  1'b0};
      8'd5:    g = '{1'b1, 1'b0, 4'd10, 1'b0};
      8'd6:    g = '{1'b1, 1'b0, 4'd8,  1'b0};
      8'd7:    g = '{1'b1, 1'b0, 4'd5,  1'b0};
      8'd32:   g = '{1'b1, 1'b1, 4'd12, 1'b0};
      8'd33:   g = '{1'b1, 1'b1, 4'd6,  1'b0};
      8'd38:   g = '{1'b1, 1'b1, 4'd8,  1'b0};
      8'd39:   g = '{1'b1, 1'b1, 4'd4,  1'b0};
      8'd40:   g = '{1'b1, 1'b1, 4'd2,  1'b0};
      default: g = '0;
    endcase
    return g;
  endfunction

  state_e      state_q, state_d;
  phase_e      ph_q, ph_d;
  logic [19:0] hx_q, hx_d;
  logic [13:0] hy_q, hy_d;
  logic [7:0]  ca_q, ca_d;
  logic [11:0] la_q, la_d;
  logic [13:0] rl_q, rl_d;
  logic [5:0]  st_q, st_d;
  logic [1:0]  sc_q, sc_d;
  logic        lq_q, lq_d;
  logic [7:0]  cs_q, cs_d;
  logic [7:0]  fa_q, fa_d;
  logic [15:0] cl_q, cl_d;
  logic [3:0]  step_q, step_d;
  logic        fast_q, fast_d;
  logic [7:0]  prev_q, prev_d;
  logic [1:0]  band_q, band_d;
  // tab stop remainder unit
  logic [20:0] num_q, num_d;
  logic [10:0] t_q, t_d;
  logic [10:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;

  job_t job;

  always_comb begin
    logic [7:0]  b;
    logic        wrap_chk, sh_v, pg, start_gr, end_col;
    logic [11:0] sh_amt;
    logic [14:0] ny;
    logic [11:0] rem_sh, rem_nx;
    logic [20:0] div_x;
    logic [10:0] t;
    logic [7:0]  sym, bm;
    logic        cs_eff;
    logic [15:0] d16, prod;
    logic [22:0] sdx, rx;
    logic [14:0] rr;
    logic [19:0] ax;
    gmode_t      gm;

    b        = in_i.data_byte;
    state_d  = state_q;
    ph_d     = ph_q;
    hx_d     = hx_q;
    hy_d     = hy_q;
    la_d     = la_q;
    rl_d     = rl_q;
    st_d     = st_q;
    sc_d     = sc_q;
    lq_d     = lq_q;
    cs_d     = cs_q;
    fa_d     = fa_q;
    cl_d     = cl_q;
    step_d   = step_q;
    fast_d   = fast_q;
    prev_d   = prev_q;
    band_d   = band_q;
    num_d    = num_q;
    t_d      = t_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    job      = '0;
    wrap_chk = 1'b0;
    sh_v     = 1'b0;
    sh_amt   = '0;
    pg       = 1'b0;
    start_gr = 1'b0;
    end_col  = 1'b0;
    gm       = '0;
    t        = {ca_q, 3'b000};
    sym      = '0;
    cs_eff   = 1'b0;
    bm       = b;
    d16      = {b, fa_q};
    prod     = 16'(ca_q) * 16'(b);
    sdx      = {{7{d16[15]}}, d16};
    rx       = {3'b0, hx_q} + {sdx[20:0], 2'b00} + (lq_q ? 23'd0 : {sdx[21:0], 1'b0});
    rr       = cols_x72(cfg_i.default_columns);
    ax       = {d16, 3'b000} + {1'b0, d16, 2'b00};

    // one restoring step per cycle, most significant bit first
    rem_sh = {rem_q, num_q[cnt_q]};
    rem_nx = (rem_sh >= {1'b0, t_q}) ? rem_sh - {1'b0, t_q} : rem_sh;
    div_x  = num_q - {10'b0, rem_nx[10:0]};

    if (state_q == STab) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 5'd1;
        rem_d = rem_nx[10:0];
      end else if (!q_full_i) begin
        // finish only with a queue slot free, a wrap may end the page
        hx_d     = (div_x > {1'b0, XMax}) ? XMax : div_x[19:0];
        wrap_chk = 1'b1;
        state_d  = SIdle;
      end
    end else if (in_i.valid && in_i.ready) begin
      case (ph_q)
        PhEsc: begin
          ph_d = PhIdle;
          case (b)
            "U", "N", "/", " ", "t", "w", CcEm: ph_d = PhSkip1;
            ":":      ph_d = PhSkip3;
            "B", "D": ph_d = PhSkipZ;
            "x":      ph_d = PhQual;
            "P":      st_d[StEl] = 1'b0;
            "M":      st_d[StEl] = 1'b1;
            CcSi:     st_d[StKs] = 1'b1;
            CcSo:     st_d[StSp] = 1'b1;
            "0":      la_d = 12'd90;
            "1":      la_d = 12'd70;
            "2":      la_d = 12'd120;
            "A":      ph_d = PhLsA;
            "3":      ph_d = PhLs3;
            "J":      ph_d = PhLsJ;
            "C":      ph_d = PhPlen;
            "Q":      ph_d = PhRmar;
            "K": begin start_gr = 1'b1; gm = gmode_of(8'd0); end
            "L": begin start_gr = 1'b1; gm = gmode_of(8'd1); end
            "Y": begin start_gr = 1'b1; gm = gmode_of(8'd2); end
            "Z": begin start_gr = 1'b1; gm = gmode_of(8'd3); end
            "*":      ph_d = PhGmode;
            "R":      ph_d = PhCset;
            "<":      hx_d = '0;
            "$":      ph_d = PhAbsLo;
            "\\":     ph_d = PhRelLo;
            "E":      st_d[StFe] = 1'b1;
            "F":      st_d[StFe] = 1'b0;
            "G":      st_d[StDo] = 1'b1;
            "H": begin
              st_d[StDo] = 1'b0;
              sc_d       = '0;
            end
            "-":      ph_d = PhUndl;
            "S":      ph_d = PhScript;
            "T":      sc_d = '0;
            "W":      ph_d = PhWide;
            "!":      ph_d = PhMaster;
            "@": begin
              // printer initialize
              hx_d = '0;
              hy_d = '0;
              lq_d = 1'b0;
              st_d = '0;
              sc_d = '0;
              cs_d = '0;
              la_d = 12'd120;
              rl_d = rr[14] ? 14'h3FFF : rr[13:0];
            end
            default:  ph_d = PhIdle;
          endcase
        end
        PhSkip1: ph_d = PhIdle;
        PhSkip2: ph_d = PhSkip1;
        PhSkip3: ph_d = PhSkip2;
        PhSkipZ: if (b == 8'd0) ph_d = PhIdle;
        PhQual: begin
          lq_d = (b != 8'd0) && (b != "0");
          ph_d = PhIdle;
        end
        PhLsA: begin
          la_d = {b, 3'b000} + {1'b0, b, 2'b00} - 12'd0;
          ph_d = PhIdle;
        end
        PhLs3: begin
          la_d = {2'b00, b, 2'b00};
          ph_d = PhIdle;
        end
        PhLsJ: begin
          ph_d   = PhIdle;
          sh_v   = 1'b1;
          sh_amt = {2'b00, b, 2'b00};
        end
        PhPlen: ph_d = (b == 8'd0) ? PhSkip1 : PhIdle;
        PhRmar: begin
          if (b != 8'd0 && prod <= 16'd5760) rl_d = prod[13:0];
          ph_d = PhIdle;
        end
        PhGmode: begin
          ph_d     = PhIdle;
          gm       = gmode_of(b);
          start_gr = gm.ok;
        end
        PhCset: begin
          cs_d = b;
          ph_d = PhIdle;
        end
        PhUndl: begin
          st_d[StUn] = (b != 8'd0) && (b != "0");
          ph_d       = PhIdle;
        end
        PhScript: begin
          sc_d[ScSup] = (b == 8'd0) || (b == "0");
          sc_d[ScSub] = (b == 8'd1) || (b == "1");
          ph_d        = PhIdle;
        end
        PhWide: begin
          st_d[StSp] = (b != 8'd0) && (b != "0");
          ph_d       = PhIdle;
        end
        PhMaster: begin
          st_d       = st_q & (6'd1 << StUn);
          st_d[StEl] = b[0];
          st_d[StKs] = !b[0] && b[2];
          st_d[StFe] = !b[0] && b[3];
          st_d[StDo] = b[4];
          st_d[StSp] = b[5];
          ph_d       = PhIdle;
        end
        PhAbsLo: begin
          fa_d = b;
          ph_d = PhAbsHi;
        end
        PhAbsHi: begin
          hx_d = ax;
          ph_d = PhIdle;
        end
        PhRelLo: begin
          fa_d = b;
          ph_d = PhRelHi;
        end
        PhRelHi: begin
          if (rx[22]) hx_d = '0;
          else if (rx > {3'b0, XMax}) hx_d = XMax;
          else hx_d = rx[19:0];
          ph_d = PhIdle;
        end
        PhC9Lo: begin
          fa_d = b;
          ph_d = PhC9Hi;
        end
        PhC24Lo: begin
          fa_d = b;
          ph_d = PhC24Hi;
        end
        PhC9Hi, PhC24Hi: begin
          cl_d = d16;
          if (d16 == '0) ph_d = PhIdle;
          else ph_d = (ph_q == PhC9Hi) ? PhDot9 : PhDot24;
        end
        PhDot9: begin
          if (fast_q) begin
            bm     = b & ~prev_q;
            prev_d = bm;
          end
          job.dots = bm;
          job.dx   = {9'b0, cfg_i.margin_left} + {1'b0, hx_q};
          job.dy0  = {3'b0, cfg_i.margin_top} + {1'b0, hy_q};
          job.pin9 = 1'b1;
          end_col  = 1'b1;
        end
        PhDot24: begin
          job.dots = b;
          job.dx   = {9'b0, cfg_i.margin_left} + {1'b0, hx_q};
          job.dy0  = {3'b0, cfg_i.margin_top} + {1'b0, hy_q} + {8'b0, band_q, 5'b0};
          job.pin9 = 1'b0;
          if (band_q >= 2'd2) begin
            band_d  = '0;
            end_col = 1'b1;
          end else begin
            band_d = band_q + 2'd1;
          end
        end
        default: begin
          ph_d = PhIdle;
          case (b)
            CcNul, CcBel, CcDc1, CcDc3, CcDel: wrap_chk = 1'b1;
            CcCan, CcFf: pg = 1'b1;
            CcBs: begin
              hx_d     = (hx_q > {12'b0, ca_q}) ? hx_q - {12'b0, ca_q} : '0;
              wrap_chk = 1'b1;
            end
            CcHt: begin
              // next multiple of eight columns through the remainder unit
              if (t == '0) begin
                wrap_chk = 1'b1;
              end else begin
                num_d   = {1'b0, hx_q} + {10'b0, t};
                t_d     = t;
                rem_d   = '0;
                cnt_d   = 5'd20;
                state_d = STab;
              end
            end
            CcLf: begin
              sh_v   = 1'b1;
              sh_amt = la_q;
            end
            CcVt: begin
              hx_d   = '0;
              sh_v   = 1'b1;
              sh_amt = la_q;
            end
            CcCr: begin
              hx_d     = '0;
              wrap_chk = 1'b1;
            end
            CcSo: begin
              st_d[StSp] = 1'b1;
              wrap_chk   = 1'b1;
            end
            CcSi: begin
              st_d[StKs] = 1'b1;
              wrap_chk   = 1'b1;
            end
            CcDc2: begin
              st_d[StKs] = 1'b0;
              wrap_chk   = 1'b1;
            end
            CcDc4: begin
              st_d[StSp] = 1'b0;
              wrap_chk   = 1'b1;
            end
            CcEsc: ph_d = PhEsc;
            default: begin
              if ((b >= 8'd32 && b <= 8'd126) || b >= 8'd160) begin
                cs_eff = (cs_q ^ {7'b0, b > 8'd128}) != '0;
                sym    = {1'b0, b[6:0]};
                if (b[6] && cs_eff) sym = sym + 8'd68;
                job.glyph_v     = 1'b1;
                job.glyph_index = sym - 8'd32;
                job.gx          = {9'b0, cfg_i.margin_left} + {1'b0, hx_q};
                job.gy          = {3'b0, cfg_i.margin_top} + {1'b0, hy_q};
              end
              hx_d     = sat_add(hx_q, ca_q);
              wrap_chk = 1'b1;
            end
          endcase
        end
      endcase

      if (start_gr) begin
        step_d = gm.step;
        if (gm.pin24) begin
          fast_d = 1'b0;
          band_d = '0;
          ph_d   = PhC24Lo;
        end else begin
          fast_d = gm.fast;
          prev_d = '0;
          ph_d   = PhC9Lo;
        end
      end

      if (end_col) begin
        hx_d = sat_add(hx_q, {4'b0, step_q});
        cl_d = cl_q - 16'd1;
        if (cl_d == '0) ph_d = PhIdle;
      end
    end

    // right limit wrap
    if (wrap_chk && hx_d >= {6'b0, rl_q}) begin
      hx_d   = '0;
      sh_v   = 1'b1;
      sh_amt = la_q;
    end

    // vertical feed and page overflow
    ny = {1'b0, hy_q} + {3'b0, sh_amt};
    if (sh_v) begin
      if (ny >= {1'b0, cfg_i.page_length}) pg = 1'b1;
      else hy_d = ny[13:0];
    end
    if (pg) begin
      hx_d       = '0;
      hy_d       = '0;
      job.page_v = 1'b1;
    end

    // attributes as they stand once this byte is done
    ca_d = pitch_of(st_d);

    job.attr.pitch         = ca_d;
    job.attr.underline     = st_d[StUn];
    job.attr.superscript   = sc_d[ScSup];
    job.attr.subscript     = sc_d[ScSub];
    job.attr.expanded      = st_d[StSp];
    job.attr.bold          = st_d[StFe];
    job.attr.double_strike = st_d[StDo];
  end

  assign in_i.ready = (state_q == SIdle) && !q_full_i;
  assign q_push_o   = job.glyph_v || (job.dots != '0) || job.page_v;
  assign q_job_o    = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ph_q    <= PhIdle;
      hx_q    <= '0;
      hy_q    <= '0;
      ca_q    <= 8'd72;
      la_q    <= 12'd120;
      rl_q    <= RightLimitRst;
      st_q    <= '0;
      sc_q    <= '0;
      lq_q    <= 1'b0;
      cs_q    <= '0;
      fa_q    <= '0;
      cl_q    <= '0;
      step_q  <= '0;
      fast_q  <= 1'b0;
      prev_q  <= '0;
      band_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
      ca_q    <= ca_d;
      la_q    <= la_d;
      rl_q    <= rl_d;
      st_q    <= st_d;
      sc_q    <= sc_d;
      lq_q    <= lq_d;
      cs_q    <= cs_d;
      fa_q    <= fa_d;
      cl_q    <= cl_d;
      step_q  <= step_d;
      fast_q  <= fast_d;
      prev_q  <= prev_d;
      band_q  <= band_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    t_q   <= t_d;
    rem_q <= rem_d;
  end

endmodule

[design/escp_jobq.sv]
// small queue of output work between decoder and emitter
`timescale 1ns / 1ps
`include "escp_printer_command_interpreter_macros.svh"
module escp_jobq #(
  parameter int unsigned Depth = escp_pkg::JobQDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  escp_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output escp_pkg::job_t job_o,
  output logic           empty_o
);
  import escp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + PtrW'(1);
    end
    if (pop_i) begin
      rp_d = (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + PtrW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

  `ESCP_ASSERT(a_q_no_overflow, push_i |-> !full_o, "push into full job queue")
  `ESCP_ASSERT(a_q_no_underflow, pop_i |-> !empty_o, "pop from empty job queue")
  `ESCP_ASSERT(a_q_count_range, cnt_q <= CntW'(Depth), "job queue count out of range")

endmodule

[design/escp_back.sv]
// emitter: expands queued work into result transactions, one per cycle while out_o is not stalled
`timescale 1ns / 1ps
`include "escp_printer_command_interpreter_macros.svh"
module escp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  escp_pkg::job_t job_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  escp_out_if.source     out_o
);
  import escp_pkg::*;

  logic        act_q, act_d;
  job_t        cur_q, cur_d;
  logic        g_q, g_d, p_q, p_d;
  logic [7:0]  mask_q, mask_d;
  logic        ov_q, ov_d;
  kind_e       kind_q, kind_d;
  logic [20:0] x_q, x_d;
  logic [14:0] y_q, y_d;
  logic [7:0]  gi_q, gi_d;
  attr_t       attr_q, attr_d;
  logic        last_q, last_d;

  always_comb begin
    logic       slot, found;
    logic [2:0] idx;
    logic [6:0] off;

    slot  = !ov_q || out_o.ready;
    found = 1'b0;
    idx   = '0;
    // first pin from the top of the byte
    for (int i = 0; i < 8; i++) begin
      if (!found && mask_q[7-i]) begin
        found = 1'b1;
        idx   = 3'(i);
      end
    end
    off = cur_q.pin9 ? ({2'b00, idx, 2'b00} + {1'b0, idx, 3'b000}) : {2'b00, idx, 2'b00};

    act_d  = act_q;
    cur_d  = cur_q;
    g_d    = g_q;
    p_d    = p_q;
    mask_d = mask_q;
    ov_d   = ov_q;
    kind_d = kind_q;
    x_d    = x_q;
    y_d    = y_q;
    gi_d   = gi_q;
    attr_d = attr_q;
    last_d = last_q;
    q_pop_o = !act_q && !q_empty_i;

    if (slot) begin
      ov_d = 1'b0;
      if (act_q) begin
        ov_d   = 1'b1;
        attr_d = cur_q.attr;
        if (g_q) begin
          kind_d = KindGlyph;
          x_d    = cur_q.gx;
          y_d    = cur_q.gy;
          gi_d   = cur_q.glyph_index;
          g_d    = 1'b0;
        end else if (found) begin
          kind_d = KindDot;
          x_d    = cur_q.dx;
          y_d    = cur_q.dy0 + {8'b0, off};
          gi_d   = '0;
          mask_d = mask_q & ~(8'h80 >> idx);
        end else begin
          kind_d = KindPage;
          x_d    = '0;
          y_d    = '0;
          gi_d   = '0;
          p_d    = 1'b0;
        end
        last_d = !(g_d || (mask_d != '0) || p_d);
        act_d  = !last_d;
      end
    end

    if (q_pop_o) begin
      cur_d  = job_i;
      g_d    = job_i.glyph_v;
      mask_d = job_i.dots;
      p_d    = job_i.page_v;
      act_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      ov_q   <= 1'b0;
      g_q    <= 1'b0;
      p_q    <= 1'b0;
      mask_q <= '0;
    end else begin
      act_q  <= act_d;
      ov_q   <= ov_d;
      g_q    <= g_d;
      p_q    <= p_d;
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    kind_q <= kind_d;
    x_q    <= x_d;
    y_q    <= y_d;
    gi_q   <= gi_d;
    attr_q <= attr_d;
    last_q <= last_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.kind          = kind_q;
  assign out_o.x_pos         = x_q;
  assign out_o.y_pos         = y_q;
  assign out_o.glyph_index   = gi_q;
  assign out_o.pitch         = attr_q.pitch;
  assign out_o.underline     = attr_q.underline;
  assign out_o.superscript   = attr_q.superscript;
  assign out_o.subscript     = attr_q.subscript;
  assign out_o.expanded      = attr_q.expanded;
  assign out_o.bold          = attr_q.bold;
  assign out_o.double_strike = attr_q.double_strike;
  assign out_o.last          = last_q;

  `ESCP_ASSERT(a_bk_progress, (act_q && !ov_q) |=> ov_q, "emitter stalled with free slot")
  `ESCP_ASSERT(a_bk_page_zero, (ov_q && kind_q == KindPage) |-> (x_q == '0 && y_q == '0),
               "page end with nonzero position")
  `ESCP_ASSERT(a_bk_pop_idle, q_pop_o |-> !act_q, "queue popped while a job is active")

endmodule

[design/escp_printer_command_interpreter.sv]
// top level of the dot-matrix printer command interpreter
`timescale 1ns / 1ps
// usage
// - in_i carries the command stream, one byte per transaction (valid/ready)
// - out_o carries results: dot strikes, glyph events and page ends; last marks
//   the final result caused by one byte
// - the apb port holds margin_left, margin_top, page_length, default_columns at
//   byte addresses 0, 4, 8, 12; pready is always high; write only while idle
// - the decoder takes one byte per cycle when the queue has room and no tab runs,
//   and updates printer state at once; a horizontal tab holds it while the
//   remainder unit works one bit per cycle, more if it waits for a free queue entry
// - output work passes through a two-entry queue to the emitter, which loads a
//   job and then gives one result per cycle while out_o is not stalled; a
//   bit-image byte with n strikes occupies it for the load and its n results
// - a first result passes the queue, then the emitter's job and result registers
// - when out_o is stalled the emitter holds its registered result, the queue
//   fills and in_i.ready drops; bytes that cause no result keep flowing until then
// - reset restores the power-up printer state at once; no clearing pass
module escp_printer_command_interpreter #(
  parameter int unsigned JobQDepth = escp_pkg::JobQDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  escp_in_if.sink     in_i,
  escp_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import escp_pkg::*;

  localparam logic [1:0] RegMarginLeft = 2'd0;
  localparam logic [1:0] RegMarginTop  = 2'd1;
  localparam logic [1:0] RegPageLen    = 2'd2;
  localparam logic [1:0] RegDefCols    = 2'd3;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_wjob, q_rjob;

  // register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        RegMarginLeft: cfg_d.margin_left     = pwdata[11:0];
        RegMarginTop:  cfg_d.margin_top      = pwdata[11:0];
        RegPageLen:    cfg_d.page_length     = pwdata[13:0];
        RegDefCols:    cfg_d.default_columns = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegMarginLeft: prdata = {20'b0, cfg_q.margin_left};
      RegMarginTop:  prdata = {20'b0, cfg_q.margin_top};
      RegPageLen:    prdata = {18'b0, cfg_q.page_length};
      RegDefCols:    prdata = {24'b0, cfg_q.default_columns};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin_left     <= MarginLeftRst;
      cfg_q.margin_top      <= MarginTopRst;
      cfg_q.page_length     <= PageLenRst;
      cfg_q.default_columns <= DefColsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // decoder: parses bytes and queues work
  escp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (q_wjob)
  );

  escp_jobq #(
    .Depth (JobQDepth)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_wjob),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_rjob),
    .empty_o (q_empty)
  );

  // emitter: one result transaction per cycle while out_o is not stalled
  escp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (q_rjob),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

[sim/testbench.sv]
// self-checking testbench for the printer command interpreter: stream stimulus and scoreboard
`timescale 1ns / 1ps
module testbench;
  import escp_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned SettleCycles  = 40;   // covers a tab in the decoder plus the queue

  // register addresses on the apb port
  localparam logic [3:0] AddrMarginLeft = 4'd0;
  localparam logic [3:0] AddrMarginTop  = 4'd4;
  localparam logic [3:0] AddrPageLen    = 4'd8;
  localparam logic [3:0] AddrDefCols    = 4'd12;

  localparam logic [7:0] ChEsc = 8'd27;
  localparam logic [7:0] ChBs  = 8'd8;
  localparam logic [7:0] ChTab = 8'd9;
  localparam logic [7:0] ChLf  = 8'd10;
  localparam logic [7:0] ChVt  = 8'd11;
  localparam logic [7:0] ChFf  = 8'd12;
  localparam logic [7:0] ChCr  = 8'd13;

  // style and script flag bits
  localparam int unsigned StElite  = 1;
  localparam int unsigned StCond   = 2;
  localparam int unsigned StEmph   = 4;
  localparam int unsigned StDouble = 8;
  localparam int unsigned StWide   = 16;
  localparam int unsigned StUnder  = 32;
  localparam int unsigned ScSuper  = 1;
  localparam int unsigned ScSub    = 2;

  typedef enum int unsigned {
    PhIdle, PhEsc, PhSkip1, PhSkip2, PhSkip3, PhSkipZ, PhQual, PhLsA, PhLs3, PhLsJ,
    PhPlen, PhRmar, PhGmode, PhCset, PhUndl, PhScript, PhWide, PhMaster, PhAbsLo,
    PhAbsHi, PhRelLo, PhRelHi, PhC9Lo, PhC9Hi, PhC24Lo, PhC24Hi, PhDot9, PhDot24
  } parse_e;

  typedef struct packed {
    kind_e       kind;
    logic [20:0] x_pos;
    logic [14:0] y_pos;
    logic [7:0]  glyph_index;
    logic [7:0]  pitch;
    logic        underline;
    logic        superscript;
    logic        subscript;
    logic        expanded;
    logic        bold;
    logic        double_strike;
    logic        last;
  } mark_t;

  // predicts the marks each byte causes and checks them in order
  class print_book;
    int unsigned ml, mt, pl, dc;
    int unsigned hx, hy, adv, lsp, rlim, style, script, lq, cset;
    int unsigned arg, cols, step, fast, prev, band;
    parse_e      phase;
    mark_t       due[$];
    mark_t       burst[$];
    int unsigned errors;

    function new();
      ml = MarginLeftRst; mt = MarginTopRst; pl = PageLenRst; dc = DefColsRst;
      phase = PhIdle; arg = 0; cols = 0; step = 0; fast = 0; prev = 0; band = 0;
      errors = 0;
      head_reset();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void set_reg(logic [3:0] addr, int unsigned v);
      case (addr)
        AddrMarginLeft: ml = v & 12'hFFF;
        AddrMarginTop:  mt = v & 12'hFFF;
        AddrPageLen:    pl = v & 14'h3FFF;
        default:        dc = v & 8'hFF;
      endcase
    endfunction

    function void put(kind_e k, int unsigned x, int unsigned y, int unsigned g);
      mark_t m;
      if (burst.size() >= 8) return;
      m.kind          = k;
      m.x_pos         = (k == KindPage) ? 21'd0 : 21'((ml + x) & 32'h1FFFFF);
      m.y_pos         = (k == KindPage) ? 15'd0 : 15'((mt + y) & 32'h7FFF);
      m.glyph_index   = 8'(g);
      m.pitch         = 8'(adv);
      m.underline     = (style & StUnder) != 0;
      m.superscript   = (script & ScSuper) != 0;
      m.subscript     = (script & ScSub) != 0;
      m.expanded      = (style & StWide) != 0;
      m.bold          = (style & StEmph) != 0;
      m.double_strike = (style & StDouble) != 0;
      m.last          = 1'b0;
      burst.push_back(m);
    endfunction

    function void set_pitch();
      int unsigned a;
      a = 72;
      if (style & StElite) a = 60;
      else if (style & StCond) a = 42;
      if (style & StWide) a = a * 2;
      adv = a;
    endfunction

    function void move_x(longint unsigned d);
      longint unsigned nx;
      nx = hx + d;
      hx = (nx > XMax) ? XMax : int'(nx);
    endfunction

    function void page_end();
      hx = 0; hy = 0;
      put(KindPage, 0, 0, 0);
    endfunction

    function void feed(int unsigned amount);
      int unsigned ny;
      ny = hy + amount;
      if (ny >= pl) page_end();
      else hy = ny & 14'h3FFF;
    endfunction

    function void head_reset();
      int unsigned r;
      hx = 0; hy = 0; lq = 0; style = 0; script = 0; cset = 0; lsp = 120;
      set_pitch();
      r = adv * dc;
      rlim = (r > 16383) ? 16383 : r;
    endfunction

    function void image9(int unsigned s, int unsigned f);
      step = s; fast = f; prev = 0; phase = PhC9Lo;
    endfunction

    function void image24(int unsigned s);
      step = s; fast = 0; band = 0; phase = PhC24Lo;
    endfunction

    function void next_column();
      move_x(step);
      cols = (cols - 1) & 16'hFFFF;
      if (cols == 0) phase = PhIdle;
    endfunction

    function void plain(int unsigned b);
      int unsigned t, c, cs, sym;
      longint unsigned nx;
      case (b)
        0, 7, 17, 19, 127: ;
        24, 12: begin page_end(); return; end
        8: hx = (hx > adv) ? hx - adv : 0;
        9: begin
          t = adv * 8;
          if (t != 0) begin
            nx = hx + t;
            nx = (nx / t) * t;
            hx = (nx > XMax) ? XMax : int'(nx);
          end
        end
        10: begin feed(lsp); return; end
        11: begin hx = 0; feed(lsp); return; end
        13: hx = 0;
        14: begin style |= StWide; set_pitch(); end
        15: begin style |= StCond; set_pitch(); end
        18: begin style &= ~StCond; set_pitch(); end
        20: begin style &= ~StWide; set_pitch(); end
        27: begin phase = PhEsc; return; end
        default: begin
          if ((b >= 32 && b <= 126) || b >= 160) begin
            cs = cset ^ ((b > 128) ? 1 : 0);
            c = b & 8'h7F;
            sym = c;
            if (c >= 64 && cs != 0) sym += 68;
            put(KindGlyph, hx, hy, (sym - 32) & 8'hFF);
          end
          move_x(adv);
        end
      endcase
      // wrap at the right limit
      if (hx >= rlim) begin
        hx = 0;
        feed(lsp);
      end
    endfunction

    function void esc_cmd(int unsigned b);
      phase = PhIdle;
      case (b)
        "U", "N", "/", " ", "t", "w", 25: phase = PhSkip1;
        ":": phase = PhSkip3;
        "B", "D": phase = PhSkipZ;
        "x": phase = PhQual;
        "P": begin style &= ~StElite; set_pitch(); end
        "M": begin style |= StElite; set_pitch(); end
        15:  begin style |= StCond; set_pitch(); end
        14:  begin style |= StWide; set_pitch(); end
        "0": lsp = 90;
        "1": lsp = 70;
        "2": lsp = 120;
        "A": phase = PhLsA;
        "3": phase = PhLs3;
        "J": phase = PhLsJ;
        "C": phase = PhPlen;
        "Q": phase = PhRmar;
        "K": image9(12, 0);
        "L": image9(6, 0);
        "Y": image9(6, 1);
        "Z": image9(3, 1);
        "*": phase = PhGmode;
        "R": phase = PhCset;
        "<": hx = 0;
        "$": phase = PhAbsLo;
        "\\": phase = PhRelLo;
        "E": style |= StEmph;
        "F": style &= ~StEmph;
        "G": style |= StDouble;
        "H": begin style &= ~StDouble; script = 0; end
        "-": phase = PhUndl;
        "S": phase = PhScript;
        "T": script = 0;
        "W": phase = PhWide;
        "!": phase = PhMaster;
        "@": head_reset();
        default: ;
      endcase
    endfunction

    function void gmode(int unsigned m);
      phase = PhIdle;
      case (m)
        0: image9(12, 0);
        1: image9(6, 0);
        2: image9(6, 1);
        3: image9(3, 1);
        4: image9(9, 0);
        5: image9(10, 0);
        6: image9(8, 0);
        7: image9(5, 0);
        32: image24(12);
        33: image24(6);
        38: image24(8);
        39: image24(4);
        40: image24(2);
        default: ;
      endcase
    endfunction

    function bit on(int unsigned b);
      return b != 0 && b != 8'h30;
    endfunction

    // work out the marks of one accepted byte
    function void take_byte(logic [7:0] data);
      int unsigned b, d;
      longint nx;
      b = data;
      burst.delete();
      case (phase)
        PhEsc:   esc_cmd(b);
        PhSkip1: phase = PhIdle;
        PhSkip2: phase = PhSkip1;
        PhSkip3: phase = PhSkip2;
        PhSkipZ: if (b == 0) phase = PhIdle;
        PhQual:  begin lq = on(b); phase = PhIdle; end
        PhLsA:   begin lsp = 12 * b; phase = PhIdle; end
        PhLs3:   begin lsp = 4 * b; phase = PhIdle; end
        PhLsJ:   begin phase = PhIdle; feed(4 * b); end
        PhPlen:  phase = (b == 0) ? PhSkip1 : PhIdle;
        PhRmar: begin
          if (b > 0 && adv * b <= 5760) rlim = adv * b;
          phase = PhIdle;
        end
        PhGmode: gmode(b);
        PhCset:  begin cset = b; phase = PhIdle; end
        PhUndl: begin
          if (on(b)) style |= StUnder; else style &= ~StUnder;
          phase = PhIdle;
        end
        PhScript: begin
          script = 0;
          if (b == 0 || b == 8'h30) script |= ScSuper;
          if (b == 1 || b == 8'h31) script |= ScSub;
          phase = PhIdle;
        end
        PhWide: begin
          if (on(b)) style |= StWide; else style &= ~StWide;
          set_pitch();
          phase = PhIdle;
        end
        PhMaster: begin
          style &= StUnder;
          if (b & 1) style |= StElite;
          else begin
            if (b & 4) style |= StCond;
            if (b & 8) style |= StEmph;
          end
          if (b & 16) style |= StDouble;
          if (b & 32) style |= StWide;
          set_pitch();
          phase = PhIdle;
        end
        PhAbsLo: begin arg = b; phase = PhAbsHi; end
        PhAbsHi: begin hx = (arg + 256 * b) * 12; phase = PhIdle; end
        PhRelLo: begin arg = b; phase = PhRelHi; end
        PhRelHi: begin
          // signed 16-bit step, clamped at zero and at the top of the range
          d = arg + 256 * b;
          nx = longint'(d) - ((d & 16'h8000) ? 65536 : 0);
          nx = longint'(hx) + nx * (lq ? 4 : 6);
          if (nx < 0) nx = 0;
          if (nx > longint'(XMax)) nx = longint'(XMax);
          hx = int'(nx);
          phase = PhIdle;
        end
        PhC9Lo:  begin arg = b; phase = PhC9Hi; end
        PhC24Lo: begin arg = b; phase = PhC24Hi; end
        PhC9Hi, PhC24Hi: begin
          cols = arg + 256 * b;
          if (cols == 0) phase = PhIdle;
          else phase = (phase == PhC9Hi) ? PhDot9 : PhDot24;
        end
        PhDot9: begin
          // fast mode drops pins that fired in the previous column
          if (fast) begin
            b = b & ~prev & 8'hFF;
            prev = b;
          end
          for (int i = 0; i < 8; i++)
            if (b & (8'h80 >> i)) put(KindDot, hx, hy + i * 12, 0);
          next_column();
        end
        PhDot24: begin
          for (int i = 0; i < 8; i++)
            if (b & (8'h80 >> i)) put(KindDot, hx, hy + band * 32 + i * 4, 0);
          if (band >= 2) begin
            band = 0;
            next_column();
          end else band++;
        end
        default: begin
          phase = PhIdle;
          plain(b);
        end
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) due.push_back(burst[i]);
    endfunction

    task match_result(mark_t got);
      mark_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = due.pop_front();
      if (got !== want) report($sformatf("got %p want %p", got, want));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  escp_in_if  byte_ch ();
  escp_out_if mark_ch ();

  print_book book = new();

  int unsigned hold_left;     // long receiver hold-off, counted down by the receiver
  bit          rx_eager;      // stretch with the receiver never stalling
  bit          tx_eager;      // stretch with the sender never pausing
  int unsigned sent;
  int unsigned quiet;

  escp_printer_command_interpreter u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (byte_ch),
    .out_o   (mark_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, short mostly, now and then long
  always @(negedge clk_i) begin
    int unsigned stall;
    bit r;
    if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else if (rx_eager) begin
      r = 1'b1;
    end else if (stall > 0) begin
      stall--;
      r = 1'b0;
    end else if ($urandom_range(9) < 3) begin
      stall = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
      r = 1'b0;
    end else r = 1'b1;
    mark_ch.ready <= r;
  end

  // result check at the rising edge
  always @(posedge clk_i) begin
    mark_t m;
    if (rst_ni && mark_ch.valid && mark_ch.ready) begin
      m.kind          = kind_e'(mark_ch.kind);
      m.x_pos         = mark_ch.x_pos;
      m.y_pos         = mark_ch.y_pos;
      m.glyph_index   = mark_ch.glyph_index;
      m.pitch         = mark_ch.pitch;
      m.underline     = mark_ch.underline;
      m.superscript   = mark_ch.superscript;
      m.subscript     = mark_ch.subscript;
      m.expanded      = mark_ch.expanded;
      m.bold          = mark_ch.bold;
      m.double_strike = mark_ch.double_strike;
      m.last          = mark_ch.last;
      book.match_result(m);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (mark_ch.valid && mark_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("[%0t] watchdog expired", $realtime);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [3:0] addr, int unsigned v);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    book.set_reg(addr, v);
  endtask

  // one byte transaction, valid stays high into the next byte unless a gap follows
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!tx_eager) begin
      case ($urandom_range(9))
        0, 1, 2: gap = $urandom_range(3, 1);
        3:       gap = ($urandom_range(4) == 0) ? $urandom_range(40, 10) : 0;
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      @(negedge clk_i);
      byte_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    book.take_byte(b);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (book.due.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_arg();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'h30;
      2:       return 8'h01;
      3:       return 8'h31;
      default: return 8'($urandom);
    endcase
  endfunction

  // one well-formed sequence with random content, or noise now and then
  task automatic send_phrase();
    logic [7:0] simple_cmds[] = '{"P", "M", 15, 14, "0", "1", "2", "<", "E", "F", "G", "H",
                                  "T", "@", "U", "N", "/", " ", "t", "w", 25, "x", "?"};
    logic [7:0] arg_cmds[] = '{"A", "3", "J", "C", "Q", "R", "-", "S", "W", "!", "x", "U"};
    logic [7:0] ctl[] = '{0, 7, 8, 9, 10, 11, 12, 13, 14, 15, 17, 18, 19, 20, 24, 127};
    logic [7:0] modes24[] = '{32, 33, 38, 39, 40};
    logic [7:0] img9[] = '{"K", "L", "Y", "Z"};
    int unsigned n;
    case ($urandom_range(19))
      0, 1, 2, 3: begin
        n = $urandom_range(6, 1);
        repeat (n) send_byte($urandom_range(1) ? 8'($urandom_range(126, 32))
                                                : 8'($urandom_range(255, 160)));
      end
      4, 5: send_byte(ctl[$urandom_range(ctl.size() - 1)]);
      6, 7: begin
        send_byte(ChEsc);
        send_byte(simple_cmds[$urandom_range(simple_cmds.size() - 1)]);
      end
      8, 9: begin
        send_byte(ChEsc);
        send_byte(arg_cmds[$urandom_range(arg_cmds.size() - 1)]);
        send_byte(pick_arg());
        if ($urandom_range(3) == 0) send_byte(pick_arg());
      end
      10: begin
        send_byte(ChEsc); send_byte($urandom_range(1) ? "$" : "\\");
        send_byte(8'($urandom)); send_byte(8'($urandom));
      end
      11: begin
        send_byte(ChEsc);
        if ($urandom_range(1)) begin
          send_byte(":"); repeat (3) send_byte(8'($urandom));
        end else begin
          send_byte($urandom_range(1) ? "B" : "D");
          repeat ($urandom_range(3)) send_byte(8'($urandom_range(255, 1)));
          send_byte(8'h00);
        end
      end
      12, 13, 14: begin
        // 9-pin image with a handful of columns
        n = $urandom_range(4);
        send_byte(ChEsc);
        if ($urandom_range(1)) send_byte(img9[$urandom_range(3)]);
        else begin send_byte("*"); send_byte(8'($urandom_range(7))); end
        send_byte(8'(n)); send_byte(8'h00);
        repeat (n) send_byte(8'($urandom));
      end
      15, 16: begin
        // 24-pin image, three bytes per column
        n = $urandom_range(2);
        send_byte(ChEsc); send_byte("*"); send_byte(modes24[$urandom_range(4)]);
        send_byte(8'(n)); send_byte(8'h00);
        repeat (3 * n) send_byte(8'($urandom));
      end
      17: begin send_byte(ChEsc); send_byte(8'($urandom)); end
      default: send_byte(8'($urandom_range(255, 28)));
    endcase
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned stop;
    stop = sent + items;
    while (sent < stop) begin
      if ($urandom_range(30) == 0) begin
        rx_eager = ~rx_eager;
        tx_eager = 1'($urandom_range(1));
      end
      send_phrase();
    end
    rx_eager = 1'b0;
    tx_eager = 1'b0;
  endtask

  initial begin
    logic [7:0] opening[] = '{8'h00, 8'hFF, "A", 8'hA0, 8'h80, ChBs, ChTab, ChCr, ChLf, ChVt,
                              ChEsc, "K", 8'h02, 8'h00, 8'hFF, 8'h81,
                              ChEsc, "*", 8'h07, ChEsc, "\\", 8'h00, 8'h80, 8'h7E, ChFf};
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    mark_ch.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_left = 0; rx_eager = 1'b0; tx_eager = 1'b0; sent = 0; quiet = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, directed extremes first
    foreach (opening[i]) send_byte(opening[i]);
    run_phase(100);
    drain();

    // tight corner: zero margins, one-dot page, one column after printer reset
    reg_write(AddrMarginLeft, 0);
    reg_write(AddrMarginTop, 0);
    reg_write(AddrPageLen, 1);
    reg_write(AddrDefCols, 1);
    send_byte(ChEsc); send_byte("@");
    // receiver holds off while the sender keeps offering, so input backs up
    hold_left = 400;
    run_phase(120);
    drain();

    // wide corner: largest margins, a page length of 15840, column count that saturates the limit
    reg_write(AddrMarginLeft, 4095);
    reg_write(AddrMarginTop, 4095);
    reg_write(AddrPageLen, 15840);
    reg_write(AddrDefCols, 255);
    send_byte(ChEsc); send_byte("@");
    run_phase(60);
    // sender waits for every expected result before going on
    drain();
    run_phase(60);
    drain();

    // middle setting
    reg_write(AddrMarginLeft, $urandom_range(4095));
    reg_write(AddrMarginTop, $urandom_range(4095));
    reg_write(AddrPageLen, $urandom_range(15840, 600));
    reg_write(AddrDefCols, $urandom_range(255, 1));
    send_byte(ChEsc); send_byte("@");
    run_phase(120);
    drain();

    foreach (book.due[i]) book.report($sformatf("missing result %p", book.due[i]));
    if (book.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
